>>> hdl/cnms_pkg.sv
// Shared constants, command and status types for the cosine nearest-match search unit.
`timescale 1ns / 1ps

package cnms_pkg;

   // Storage geometry and element format.
   localparam int MAX_ROWS  = 1024;
   localparam int MAX_DIM   = 128;
   localparam int ELEM_W    = 16;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int DIM_W     = $clog2(MAX_DIM);
   localparam int GAL_AW    = ROW_W + DIM_W;
   localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
   localparam int DIM_CNT_W = $clog2(MAX_DIM + 1);
   localparam int DIM_RESET = 128;

   // Accumulator widths: products of two elements summed over a full vector.
   localparam int PROD_W = 2 * ELEM_W;
   localparam int DOT_W  = PROD_W + DIM_W;
   localparam int SQ_W   = PROD_W - 1 + DIM_W;

   // Split multiplier for the squared-norm product and the squared dot product.
   localparam int HALF_W    = (SQ_W + 1) / 2;
   localparam int PP_W      = 2 * HALF_W;
   localparam int MUL_W     = 2 * SQ_W;
   localparam int MUL_STEPS = 4;
   localparam int MUL_SEL_W = $clog2(MUL_STEPS);

   // Score root search: 15 result bits, Q1.14 output with 2^30 scaling of the dot term.
   localparam int ROOT_STEPS = 15;
   localparam int CMP_SHIFT  = 30;
   localparam int ROOT_W     = MUL_W + CMP_SHIFT;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int SCORE_W    = ROOT_STEPS + 1;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = ROW_CNT_W;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_IN_USE  = 1'b1;

   // Request kinds.
   localparam logic REQ_GALLERY = 1'b0;
   localparam logic REQ_QUERY   = 1'b1;

   typedef struct packed {
      logic                 store_gallery;
      logic                 store_query;
      logic                 clear_acc;
      logic                 issue;
      logic [ROW_W-1:0]     row;
      logic [DIM_W-1:0]     elem;
      logic                 mul_step;
      logic [MUL_SEL_W-1:0] mul_sel;
      logic                 root_init;
      logic                 root_sum;
      logic                 root_cmp;
      logic                 best_update;
      logic                 best_first;
      logic                 rsp_load;
      logic                 rsp_empty;
   } cnms_cmd_type;

   typedef struct packed {
      logic mac_idle;
      logic zero_norm;
      logic rsp_busy;
   } cnms_status_type;

endpackage

>>> hdl/cnms_datapath.sv
// Datapath: vector stores, multiply-accumulate, norm product, score root search, result register.
`timescale 1ns / 1ps

module cnms_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cnms_pkg::cnms_cmd_type         cmd,
   output cnms_pkg::cnms_status_type      status,
   input  logic [cnms_pkg::ROW_W-1:0]     req_row_index,
   input  logic [cnms_pkg::DIM_W-1:0]     req_elem_index,
   input  logic signed [cnms_pkg::ELEM_W-1:0] req_elem_value,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [cnms_pkg::ROW_W-1:0]     rsp_best_row,
   output logic signed [cnms_pkg::SCORE_W-1:0] rsp_best_score,
   output logic                           rsp_empty_gallery
);
   import cnms_pkg::*;

   logic signed [ELEM_W-1:0]  gal_mem [0:MAX_ROWS*MAX_DIM-1];
   logic signed [ELEM_W-1:0]  qry_mem [0:MAX_DIM-1];
   logic signed [ELEM_W-1:0]  g_rd_ff, q_rd_ff;
   logic                      vld1_ff;
   logic signed [DOT_W-1:0]   dot_ff;
   logic [SQ_W-1:0]           q2_ff, g2_ff;
   logic signed [PROD_W-1:0]  qg, qq, gg;
   logic [DOT_W-1:0]          dot_neg;
   logic [SQ_W-1:0]           dot_mag;
   logic [MUL_W-1:0]          p_ff, d2_ff;
   logic [HALF_W-1:0]         pa, pb, da, db;
   logic [PP_W-1:0]           pp_p, pp_d;
   logic [MUL_W-1:0]          pp_p_ext, pp_d_ext;
   logic [ROOT_W-1:0]         a_ff, b_ff, s_ff, t_ff, d_ext, b_new;
   logic [ROOT_STEPS-1:0]     u_ff;
   logic                      fit;
   logic [ROOT_STEPS:0]       m_sum;
   logic signed [SCORE_W-1:0] score_mag, score;
   logic signed [SCORE_W-1:0] best_ff;
   logic [ROW_W-1:0]          best_row_ff;
   logic                      rsp_valid_ff;
   logic [ROW_W-1:0]          rsp_row_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic                      rsp_empty_ff;

   // Gallery store: written on a gallery transaction, read each cycle at the search address.
   always_ff @(posedge clock) begin
      if (cmd.store_gallery) begin
         gal_mem[{req_row_index, req_elem_index}] <= req_elem_value;
      end
      g_rd_ff <= gal_mem[{cmd.row, cmd.elem}];
   end

   // Query store.
   always_ff @(posedge clock) begin
      if (cmd.store_query) begin
         qry_mem[req_elem_index] <= req_elem_value;
      end
      q_rd_ff <= qry_mem[cmd.elem];
   end

   // Read data arrives in the cycle after the address is issued.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= cmd.issue;
      end
   end

   assign qg = q_rd_ff * g_rd_ff;
   assign qq = q_rd_ff * q_rd_ff;
   assign gg = g_rd_ff * g_rd_ff;

   // Dot product and squared norms of one row against the query.
   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         dot_ff <= '0;
         q2_ff  <= '0;
         g2_ff  <= '0;
      end else if (vld1_ff) begin
         dot_ff <= dot_ff + DOT_W'(qg);
         q2_ff  <= q2_ff + SQ_W'(qq[PROD_W-2:0]);
         g2_ff  <= g2_ff + SQ_W'(gg[PROD_W-2:0]);
      end
   end

   assign dot_neg = -dot_ff;
   assign dot_mag = dot_ff[DOT_W-1] ? dot_neg[SQ_W-1:0] : dot_ff[SQ_W-1:0];

   // Half-word operand selection for the four partial products.
   assign pa = cmd.mul_sel[1] ? HALF_W'(q2_ff[SQ_W-1:HALF_W]) : q2_ff[HALF_W-1:0];
   assign pb = cmd.mul_sel[0] ? HALF_W'(g2_ff[SQ_W-1:HALF_W]) : g2_ff[HALF_W-1:0];
   assign da = cmd.mul_sel[1] ? HALF_W'(dot_mag[SQ_W-1:HALF_W]) : dot_mag[HALF_W-1:0];
   assign db = cmd.mul_sel[0] ? HALF_W'(dot_mag[SQ_W-1:HALF_W]) : dot_mag[HALF_W-1:0];
   assign pp_p = pa * pb;
   assign pp_d = da * db;

   always_comb begin
      case (cmd.mul_sel)
         2'd0: begin
            pp_p_ext = MUL_W'(pp_p);
            pp_d_ext = MUL_W'(pp_d);
         end
         2'd1, 2'd2: begin
            pp_p_ext = MUL_W'(pp_p) << HALF_W;
            pp_d_ext = MUL_W'(pp_d) << HALF_W;
         end
         default: begin
            pp_p_ext = MUL_W'(pp_p) << (2 * HALF_W);
            pp_d_ext = MUL_W'(pp_d) << (2 * HALF_W);
         end
      endcase
   end

   // Norm product and squared dot product, one partial product per cycle.
   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         if (cmd.mul_sel == '0) begin
            p_ff  <= pp_p_ext;
            d2_ff <= pp_d_ext;
         end else begin
            p_ff  <= p_ff + pp_p_ext;
            d2_ff <= d2_ff + pp_d_ext;
         end
      end
   end

   // Bitwise root search for the largest u with u^2 * P <= d^2 * 2^30.
   assign d_ext = ROOT_W'(d2_ff) << CMP_SHIFT;
   assign fit   = (t_ff <= d_ext);
   assign b_new = fit ? b_ff + (a_ff << 1) : b_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         a_ff <= ROOT_W'(p_ff) << (2 * (ROOT_STEPS - 1));
         b_ff <= '0;
         s_ff <= '0;
         u_ff <= '0;
      end else if (cmd.root_sum) begin
         t_ff <= s_ff + b_ff + a_ff;
      end else if (cmd.root_cmp) begin
         if (fit) begin
            s_ff <= t_ff;
         end
         b_ff <= b_new >> 1;
         a_ff <= a_ff >> 2;
         u_ff <= {u_ff[ROOT_STEPS-2:0], fit};
      end
   end

   // Rounded score magnitude (u + 1) / 2: the m of the largest odd 2m - 1 not above u.
   assign m_sum     = {1'b0, u_ff} + (ROOT_STEPS + 1)'(1);
   assign score_mag = SCORE_W'(m_sum[ROOT_STEPS:1]);
   assign score     = status.zero_norm ? '0 :
                      (dot_ff[DOT_W-1] ? -score_mag : score_mag);

   // Running best row; ties keep the earlier row.
   always_ff @(posedge clock) begin
      if (cmd.best_update && (cmd.best_first || score > best_ff)) begin
         best_ff     <= score;
         best_row_ff <= cmd.row;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_row_ff   <= cmd.rsp_empty ? '0 : best_row_ff;
         rsp_score_ff <= cmd.rsp_empty ? '0 : best_ff;
         rsp_empty_ff <= cmd.rsp_empty;
      end
   end

   assign status.mac_idle  = !vld1_ff;
   assign status.zero_norm = (q2_ff == '0) || (g2_ff == '0);
   assign status.rsp_busy  = rsp_valid_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_row      = rsp_row_ff;
   assign rsp_best_score    = rsp_score_ff;
   assign rsp_empty_gallery = rsp_empty_ff;

   // A result register that empties did so because the receiver took it.
   a_rsp_taken: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_ready))
      else $error("result dropped without a transaction");

endmodule

>>> hdl/cnms_ctrl.sv
// Controller: configuration registers, search sequencing over rows, elements and score steps.
`timescale 1ns / 1ps

module cnms_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic                              req_query_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cnms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cnms_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output cnms_pkg::cnms_cmd_type            cmd,
   input  cnms_pkg::cnms_status_type         status
);
   import cnms_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROW_START, ST_ACCUM, ST_DRAIN, ST_MUL,
      ST_ROOT_INIT, ST_ROOT_SUM, ST_ROOT_CMP, ST_UPDATE, ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [DIM_W-1:0]       elem_ff, elem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [ROW_CNT_W-1:0]   rows_cfg_ff;
   logic [DIM_CNT_W-1:0]   dim_cfg_ff;
   logic [ROW_CNT_W-1:0]   rows_eff, rows_m1;
   logic [DIM_CNT_W-1:0]   dim_eff, dim_m1;
   logic [ROW_W-1:0]       rows_last;
   logic [DIM_W-1:0]       dim_last;
   logic                   accept;

   // Effective sizes, limited to the store geometry.
   assign rows_eff  = (rows_cfg_ff > ROW_CNT_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS) : rows_cfg_ff;
   assign dim_eff   = (dim_cfg_ff > DIM_CNT_W'(MAX_DIM)) ? DIM_CNT_W'(MAX_DIM) : dim_cfg_ff;
   assign rows_m1   = rows_eff - ROW_CNT_W'(1);
   assign dim_m1    = dim_eff - DIM_CNT_W'(1);
   assign rows_last = rows_m1[ROW_W-1:0];
   assign dim_last  = dim_m1[DIM_W-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Next state and command decode.
   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      elem_in         = elem_ff;
      step_in         = step_ff;
      cmd             = '0;
      cmd.row         = row_ff;
      cmd.elem        = elem_ff;
      cmd.mul_sel     = step_ff[MUL_SEL_W-1:0];
      cmd.best_first  = (row_ff == '0);
      cmd.rsp_empty   = (rows_eff == '0);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.store_gallery = (req_type == REQ_GALLERY);
               cmd.store_query   = (req_type == REQ_QUERY);
               if (req_type == REQ_QUERY && req_query_last) begin
                  row_in   = '0;
                  state_in = (rows_eff == '0) ? ST_EMIT : ST_ROW_START;
               end
            end
         end
         ST_ROW_START: begin
            cmd.clear_acc = 1'b1;
            elem_in       = '0;
            state_in      = (dim_eff == '0) ? ST_DRAIN : ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.issue = 1'b1;
            if (elem_ff == dim_last) begin
               state_in = ST_DRAIN;
            end else begin
               elem_in = elem_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (status.mac_idle) begin
               step_in  = '0;
               state_in = status.zero_norm ? ST_UPDATE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_ROOT_INIT;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            state_in      = ST_ROOT_SUM;
         end
         ST_ROOT_SUM: begin
            cmd.root_sum = 1'b1;
            state_in     = ST_ROOT_CMP;
         end
         ST_ROOT_CMP: begin
            cmd.root_cmp = 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               step_in  = step_ff + STEP_W'(1);
               state_in = ST_ROOT_SUM;
            end
         end
         ST_UPDATE: begin
            cmd.best_update = 1'b1;
            if (row_ff == rows_last) begin
               state_in = ST_EMIT;
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = ST_ROW_START;
            end
         end
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, loop counters and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         row_ff      <= '0;
         elem_ff     <= '0;
         step_ff     <= '0;
         rows_cfg_ff <= '0;
         dim_cfg_ff  <= DIM_CNT_W'(DIM_RESET);
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         elem_ff  <= elem_in;
         step_ff  <= step_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ROWS_IN_USE) begin
               rows_cfg_ff <= csr_wdata;
            end else if (csr_index == REG_DIM_IN_USE) begin
               dim_cfg_ff <= csr_wdata[DIM_CNT_W-1:0];
            end
         end
      end
   end

   // A new result is never loaded over one still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !status.rsp_busy)
      else $error("result register overwritten");

   // Element reads stay inside the configured vector length.
   a_elem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM) |-> (elem_ff <= dim_last))
      else $error("element index beyond vector length");

   // Score arithmetic starts only after every accumulation has landed.
   a_mac_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_ROOT_SUM) |-> status.mac_idle)
      else $error("score started with accumulation pending");

   // A final query element with rows in use starts the row walk.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_QUERY && req_query_last && rows_eff != '0)
      |=> (state_ff == ST_ROW_START))
      else $error("search did not start");

endmodule

>>> hdl/cosine_nearest_match_search_unit.sv
// Top level of the cosine nearest-match search unit.
`timescale 1ns / 1ps

// Usage: the req channel carries gallery and query element writes, one transaction
// per element. A gallery or query write gives no result. A query transaction with
// req_query_last set starts a search over the gallery rows in use; req_ready stays
// low until the search has finished and its result has been placed in the output
// register. Each row has a setup step, one gallery read per element, a drain of the
// multiply-accumulate, a split multiplication of four partial products, a root setup
// step, a bitwise root search of a sum and a compare step per result bit, and an
// update of the running best. A row with a zero norm goes from the drain straight
// to the update, as every row does when dim_in_use is zero. An empty gallery goes
// straight to its result. The rsp channel delivers one transaction per search from
// an output register; element writes are taken while it waits, but the next search
// holds in its final state until the receiver has taken the previous result. The
// csr channel is always ready; index 0 writes rows_in_use and index 1 writes
// dim_in_use, and it is to be written only while no search runs, which the block
// does not enforce. Synchronous reset clears control state, sets rows_in_use to 0
// and dim_in_use to 128; the vector stores are not cleared.

module cosine_nearest_match_search_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_type,
   input  logic [cnms_pkg::ROW_W-1:0]            req_row_index,
   input  logic [cnms_pkg::DIM_W-1:0]            req_elem_index,
   input  logic signed [cnms_pkg::ELEM_W-1:0]    req_elem_value,
   input  logic                                  req_query_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cnms_pkg::ROW_W-1:0]            rsp_best_row,
   output logic signed [cnms_pkg::SCORE_W-1:0]   rsp_best_score,
   output logic                                  rsp_empty_gallery,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cnms_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cnms_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cnms_pkg::*;

   cnms_cmd_type    cmd;
   cnms_status_type status;

   // Sequencer.
   cnms_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_query_last (req_query_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status)
   );

   // Stores and arithmetic.
   cnms_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_row_index     (req_row_index),
      .req_elem_index    (req_elem_index),
      .req_elem_value    (req_elem_value),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_best_row      (rsp_best_row),
      .rsp_best_score    (rsp_best_score),
      .rsp_empty_gallery (rsp_empty_gallery)
   );

endmodule

>>> test/cosine_nearest_match_search_unit_tb.sv
// Self-checking testbench for the cosine nearest-match search unit.
`timescale 1ns / 1ps

module cosine_nearest_match_search_unit_tb;
   import cnms_pkg::*;

   localparam int STALL_LIMIT = 40000;
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      logic             kind;
      logic [ROW_W-1:0] row;
      logic [DIM_W-1:0] elem;
      logic [15:0]      value;
      logic             last;
   } elem_write_type;

   typedef struct {
      logic [ROW_W-1:0]   row;
      logic [SCORE_W-1:0] score;
      logic               empty;
   } match_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [ROW_W-1:0] req_row_index = '0;
   logic [DIM_W-1:0] req_elem_index = '0;
   logic signed [ELEM_W-1:0] req_elem_value = '0;
   logic req_query_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ROW_W-1:0] rsp_best_row;
   logic signed [SCORE_W-1:0] rsp_best_score;
   logic rsp_empty_gallery;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cosine_nearest_match_search_unit i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mirror of the block state used for prediction.
   logic signed [15:0] gallery_mirror [MAX_ROWS*MAX_DIM];
   logic signed [15:0] query_mirror [MAX_DIM];
   int unsigned rows_cfg = 0;
   int unsigned dim_cfg = DIM_RESET;

   // Generator view of which gallery entries have been written.
   bit gal_written [MAX_ROWS*MAX_DIM];
   logic signed [15:0] qv [MAX_DIM];

   elem_write_type pending_writes [$];
   match_type      expected_matches [$];
   int unsigned n_pushed = 0, n_accepted = 0, n_matches = 0;
   int unsigned cycle_count = 0, stall_count = 0;
   int errors = 0;
   elem_write_type cur;
   int hold_left = 0;
   bit hold_done = 0;

   // Cosine score of one row in Q1.14, rounded to nearest.
   function automatic logic signed [15:0] cosine_score(int unsigned r, int unsigned d);
      longint dot;
      longint q, g;
      logic [63:0] q2, g2, ad, t;
      logic [127:0] rhs, prod;
      int unsigned lo, hi, m;
      dot = 0; q2 = 0; g2 = 0;
      for (int i = 0; i < d; i++) begin
         q = query_mirror[i];
         g = gallery_mirror[r*MAX_DIM + i];
         dot += q * g;
         q2 += q * q;
         g2 += g * g;
      end
      if (q2 == 0 || g2 == 0) return 16'sd0;
      ad = (dot < 0) ? -dot : dot;
      rhs = (128'(ad) * 128'(ad)) << 30;
      prod = 128'(q2) * 128'(g2);
      lo = 0; hi = 16384;
      while (lo < hi) begin
         m = (lo + hi + 1) / 2;
         t = 2 * 64'(m) - 1;
         if (prod * 128'(t * t) <= rhs) lo = m;
         else hi = m - 1;
      end
      return (dot < 0) ? -16'(lo) : 16'(lo);
   endfunction

   // Apply one accepted element write and predict any search result.
   task automatic apply_elem_write(elem_write_type w);
      int unsigned rows, d;
      logic signed [15:0] best, s;
      int unsigned best_r;
      match_type mt;
      if (w.kind == REQ_GALLERY) begin
         gallery_mirror[w.row*MAX_DIM + w.elem] = w.value;
         return;
      end
      query_mirror[w.elem] = w.value;
      if (!w.last) return;
      rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
      d = (dim_cfg > MAX_DIM) ? MAX_DIM : dim_cfg;
      if (rows == 0) begin
         mt.row = '0; mt.score = '0; mt.empty = 1'b1;
      end else begin
         best = cosine_score(0, d);
         best_r = 0;
         for (int r = 1; r < rows; r++) begin
            s = cosine_score(r, d);
            if (s > best) begin
               best = s;
               best_r = r;
            end
         end
         mt.row = ROW_W'(best_r); mt.score = best; mt.empty = 1'b0;
      end
      expected_matches.insert(expected_matches.size(), mt);
   endtask

   function automatic bit idle_roll();
      if (cycle_count > 3000 && cycle_count < 8000) return 0;
      return $urandom_range(0, 99) < 11;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (req_valid && req_ready) begin
            apply_elem_write(cur);
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_writes.size() != 0 && !idle_roll()) begin
               cur = pending_writes.pop_front();
               req_valid <= 1'b1;
               req_type <= cur.kind;
               req_row_index <= cur.row;
               req_elem_index <= cur.elem;
               req_elem_value <= cur.value;
               req_query_last <= cur.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with one long receiver hold-off, taken after two results while a request is pending.
   always @(posedge clock) begin
      match_type mt;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_matches++;
            if (expected_matches.size() == 0) begin
               $error("unexpected result transaction row=%0d", rsp_best_row);
               errors++;
            end else begin
               mt = expected_matches.pop_front();
               if (rsp_best_row !== mt.row) begin
                  $error("best_row expected %0d actual %0d", mt.row, rsp_best_row);
                  errors++;
               end
               if (rsp_best_score !== mt.score) begin
                  $error("best_score expected %0d actual %0d",
                         $signed(mt.score), rsp_best_score);
                  errors++;
               end
               if (rsp_empty_gallery !== mt.empty) begin
                  $error("empty_gallery expected %0d actual %0d",
                         mt.empty, rsp_empty_gallery);
                  errors++;
               end
            end
         end
         if (!hold_done && n_matches >= 2 && rsp_valid && req_valid) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !idle_roll();
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'sd1;
         4: return -16'sd1;
         5: return 16'($signed($urandom_range(0, 255)) - 128);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_write(logic kind, int unsigned row, int unsigned elem,
                             logic [15:0] value, logic last);
      elem_write_type w;
      w.kind = kind;
      w.row = ROW_W'(row);
      w.elem = DIM_W'(elem);
      w.value = value;
      w.last = last;
      if (kind == REQ_GALLERY) gal_written[row*MAX_DIM + elem] = 1;
      pending_writes.insert(pending_writes.size(), w);
      n_pushed++;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (!(n_accepted == n_pushed && expected_matches.size() == 0 && !req_valid));
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_ROWS_IN_USE) rows_cfg = value & 11'h7FF;
      else dim_cfg = value & 8'hFF;
      @(posedge clock);
   endtask

   task automatic noise_write();
      if ($urandom_range(0, 1))
         push_write(REQ_GALLERY, $urandom_range(0, MAX_ROWS-1), $urandom_range(0, MAX_DIM-1),
                    pick_value(), 1'($urandom_range(0, 1)));
      else
         push_write(REQ_QUERY, 0, $urandom_range(0, MAX_DIM-1), pick_value(), 1'b0);
   endtask

   // One search: optional register update, gallery loads mixed with noise writes, then a query ending in last.
   task automatic run_search(int unsigned rows, int unsigned dim, bit reconfig,
                             int unsigned rewrite_pct);
      int unsigned re, de, mode, j;
      longint unsigned tmp;
      longint unsigned slots [$];
      logic signed [15:0] v;
      if (reconfig) begin
         wait_idle();
         write_reg(REG_ROWS_IN_USE, rows);
         write_reg(REG_DIM_IN_USE, dim);
      end
      re = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
      de = (dim_cfg > MAX_DIM) ? MAX_DIM : dim_cfg;
      for (int e = 0; e < MAX_DIM; e++) qv[e] = pick_value();
      // Gallery rows: random, zero, equal to or opposite of the query.
      for (int r = 0; r < re; r++) begin
         mode = $urandom_range(0, 9);
         for (int e = 0; e < de; e++) begin
            if (!gal_written[r*MAX_DIM + e] || $urandom_range(0, 99) < rewrite_pct) begin
               case (mode)
                  0: v = 16'sd0;
                  1: v = qv[e];
                  2: v = -qv[e];
                  default: v = pick_value();
               endcase
               slots.insert(slots.size(),
                            (longint'(r*MAX_DIM + e) << 16) | (v & 16'hFFFF));
            end
         end
      end
      for (int i = slots.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = slots[i]; slots[i] = slots[j]; slots[j] = tmp;
      end
      foreach (slots[i]) begin
         if ($urandom_range(0, 9) == 0) noise_write();
         push_write(REQ_GALLERY, 32'((slots[i] >> 16) / MAX_DIM),
                    32'((slots[i] >> 16) % MAX_DIM), slots[i][15:0],
                    1'($urandom_range(0, 1)));
      end
      // Query elements in random order; the final one starts the search.
      slots.delete();
      for (int e = 0; e < de; e++) slots.insert(slots.size(), longint'(e));
      if (de == 0) slots.insert(slots.size(), longint'($urandom_range(0, MAX_DIM-1)));
      for (int i = slots.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = slots[i]; slots[i] = slots[j]; slots[j] = tmp;
      end
      foreach (slots[i])
         push_write(REQ_QUERY, $urandom_range(0, MAX_ROWS-1), 32'(slots[i]),
                    qv[slots[i]], i == slots.size() - 1);
   endtask

   initial begin
      int unsigned r, d;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty gallery, zero dimension, single elements at the extremes.
      run_search(0, 1, 1, 0);
      run_search(1, 0, 1, 0);
      push_write(REQ_GALLERY, 0, 0, 16'sh8000, 1'b1);
      push_write(REQ_QUERY, 5, 0, 16'sh7FFF, 1'b1);
      push_write(REQ_QUERY, 0, 0, 16'sh8000, 1'b1);
      run_search(1, 1, 1, 100);
      run_search(3, 4, 1, 100);
      run_search(3, 4, 0, 100);

      // Random searches, mostly small, with wide vectors, an over-range gallery and
      // a long row walk.
      for (int k = 0; k < 30; k++) begin
         if (k == 10) begin
            run_search(2, 255, 1, 100);
            run_search(3, 5, 1, 20);
         end else if (k == 20) begin
            run_search(2047, 0, 1, 0);
            run_search(200, 1, 1, 100);
            run_search(2, 3, 1, 20);
         end else begin
            r = $urandom_range(1, 6);
            d = $urandom_range(1, 12);
            run_search(r, d, $urandom_range(0, 1), 20);
         end
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_matches.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
